### sv/bslpm_pkg.sv
package bslpm_pkg;

   localparam int ADDR_BITS = 32;
   localparam int LEN_BITS = 3;
   localparam int PORT_FIELD_BITS = 8;
   localparam int HOP_BITS = 32;
   localparam int STATUS_BITS = 3;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [STATUS_BITS-1:0] ST_NEW     = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_UPDATED = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_HIT     = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_MISS    = 3'd4;

   localparam logic [LEN_BITS-1:0] LEN_ONE  = 3'd1;
   localparam logic [LEN_BITS-1:0] LEN_TWO  = 3'd2;
   localparam logic [LEN_BITS-1:0] LEN_FOUR = 3'd4;

   // classified transaction handed from the front to the back
   typedef struct packed {
      logic                       cmd;
      logic [LEN_BITS-1:0]        len;
      logic [ADDR_BITS-1:0]       pfx;
      logic [PORT_FIELD_BITS-1:0] port;
      logic [HOP_BITS-1:0]        next_hop;
   } op_type;

   function automatic logic [ADDR_BITS-1:0] byte_mask(input logic [LEN_BITS-1:0] len);
      logic [ADDR_BITS-1:0] mask;
      case (len)
         3'd1:    mask = 32'hFF00_0000;
         3'd2:    mask = 32'hFFFF_0000;
         3'd3:    mask = 32'hFFFF_FF00;
         default: mask = 32'hFFFF_FFFF;
      endcase
      return mask;
   endfunction

   function automatic logic [LEN_BITS-1:0] clamp_len(input logic [LEN_BITS-1:0] raw);
      logic [LEN_BITS-1:0] len;
      if (raw == '0) begin
         len = LEN_ONE;
      end else if (raw > LEN_FOUR) begin
         len = LEN_FOUR;
      end else begin
         len = raw;
      end
      return len;
   endfunction

endpackage

### sv/bslpm_ram.sv
module bslpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/bslpm_front.sv
module bslpm_front
   import bslpm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_cmd,
   input  logic [ADDR_BITS-1:0]       req_address,
   input  logic [LEN_BITS-1:0]        req_prefix_bytes,
   input  logic [PORT_FIELD_BITS-1:0] req_port,
   input  logic [HOP_BITS-1:0]        req_next_hop,
   output logic                       op_valid,
   input  logic                       op_ready,
   output op_type                     op
);

   logic   valid_ff, valid_in;
   op_type op_ff, op_in;
   logic   len_clamped;
   logic [LEN_BITS-1:0] len;

   assign len_clamped = 1'b1;
   assign len = clamp_len(req_prefix_bytes);

   assign req_ready = !valid_ff || op_ready;

   always_comb begin
      op_in          = op_ff;
      op_in.cmd      = req_cmd;
      op_in.len      = len;
      // drop the bytes below the prefix length on insert
      op_in.pfx      = (req_cmd == CMD_INSERT) ? (req_address & byte_mask(len))
                                               : req_address;
      op_in.port     = req_port;
      op_in.next_hop = req_next_hop;
   end

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid && len_clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_ready && req_valid) begin
         op_ff <= op_in;
      end
   end

   assign op_valid = valid_ff;
   assign op = op_ff;

endmodule

### sv/bslpm_queue.sv
module bslpm_queue
   import bslpm_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   in_valid,
   output logic   in_ready,
   input  op_type in_op,
   output logic   out_valid,
   input  logic   out_ready,
   output op_type out_op
);

   op_type     entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;

   assign in_ready  = (fill_ff != 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_op    = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_op;
      end
   end

endmodule

### sv/bslpm_back.sv
module bslpm_back
   import bslpm_pkg::*;
#(
   parameter int ROUTES = 256,
   parameter int PORT_BITS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       op_valid,
   output logic                       op_ready,
   input  op_type                     op,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_BITS-1:0]     rsp_status,
   output logic [PORT_FIELD_BITS-1:0] rsp_out_port,
   output logic [HOP_BITS-1:0]        rsp_out_next_hop
);

   localparam int IW = $clog2(ROUTES);
   localparam int CW = $clog2(ROUTES + 1);
   localparam int EW = LEN_BITS + ADDR_BITS + PORT_BITS + HOP_BITS;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   logic [1:0]  state_ff, state_in;
   op_type      op_ff, op_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic        pend_ff, pend_in;
   logic [IW-1:0] ridx_ff, ridx_in;
   logic        found_ff, found_in;
   logic [IW-1:0] slot_ff, slot_in;
   logic [LEN_BITS-1:0] best_ff, best_in;
   logic [PORT_BITS-1:0] hit_port_ff, hit_port_in;
   logic [HOP_BITS-1:0]  hit_nh_ff, hit_nh_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]     status_ff, status_in;
   logic [PORT_FIELD_BITS-1:0] oport_ff, oport_in;
   logic [HOP_BITS-1:0]        onh_ff, onh_in;

   logic          rd_en, wr_en;
   logic [IW-1:0] rd_addr, wr_addr;
   logic [EW-1:0] rd_data, wr_data;
   logic [LEN_BITS-1:0]  e_len;
   logic [ADDR_BITS-1:0] e_pfx;
   logic [PORT_BITS-1:0] e_port;
   logic [HOP_BITS-1:0]  e_nh;
   logic out_free;

   bslpm_ram #(.WIDTH(EW), .DEPTH(ROUTES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign {e_len, e_pfx, e_port, e_nh} = rd_data;

   assign op_ready = (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // entries below the fill count are the valid ones
   assign rd_en   = (state_ff == S_SCAN) && (issue_ff != count_ff);
   assign rd_addr = issue_ff[IW-1:0];
   assign wr_data = {op_ff.len, op_ff.pfx, PORT_BITS'(op_ff.port), op_ff.next_hop};

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      pend_in      = rd_en;
      ridx_in      = rd_addr;
      found_in     = found_ff;
      slot_in      = slot_ff;
      best_in      = best_ff;
      hit_port_in  = hit_port_ff;
      hit_nh_in    = hit_nh_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      oport_in     = oport_ff;
      onh_in       = onh_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;

      if (pend_ff) begin
         if (op_ff.cmd == CMD_INSERT) begin
            if (!found_ff && e_len == op_ff.len && e_pfx == op_ff.pfx) begin
               found_in = 1'b1;
               slot_in  = ridx_ff;
            end
         end else if (e_len > best_ff && (op_ff.pfx & byte_mask(e_len)) == e_pfx) begin
            best_in     = e_len;
            hit_port_in = e_port;
            hit_nh_in   = e_nh;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (op_valid) begin
               op_in    = op;
               issue_in = '0;
               found_in = 1'b0;
               best_in  = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (rd_en) begin
               issue_in = issue_ff + CW'(1);
            end else if (!pend_ff) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               oport_in     = '0;
               onh_in       = '0;
               if (op_ff.cmd == CMD_INSERT) begin
                  if (found_ff) begin
                     wr_en     = 1'b1;
                     status_in = ST_UPDATED;
                  end else if (count_ff != CW'(ROUTES)) begin
                     wr_en     = 1'b1;
                     wr_addr   = count_ff[IW-1:0];
                     count_in  = count_ff + CW'(1);
                     status_in = ST_NEW;
                  end else begin
                     status_in = ST_FULL;
                  end
               end else if (best_ff != '0) begin
                  status_in = ST_HIT;
                  oport_in  = PORT_FIELD_BITS'(hit_port_ff);
                  onh_in    = hit_nh_ff;
               end else begin
                  status_in = ST_MISS;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      ridx_ff     <= ridx_in;
      slot_ff     <= slot_in;
      hit_port_ff <= hit_port_in;
      hit_nh_ff   <= hit_nh_in;
      status_ff   <= status_in;
      oport_ff    <= oport_in;
      onh_ff      <= onh_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_port     = oport_ff;
   assign rsp_out_next_hop = onh_ff;

endmodule

### sv/byte_stride_longest_prefix_match.sv
// For each transaction the back end reads every stored route once through the single read
// port of the route memory, and it takes no new transaction before its response is issued.
// Reset clears all control state and the fill count, so the table starts empty
// at once; route memory contents are not cleared.
module byte_stride_longest_prefix_match
   import bslpm_pkg::*;
#(
   parameter int ROUTES = 256,
   parameter int PORT_BITS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_cmd,
   input  logic [ADDR_BITS-1:0]       req_address,
   input  logic [LEN_BITS-1:0]        req_prefix_bytes,
   input  logic [PORT_FIELD_BITS-1:0] req_port,
   input  logic [HOP_BITS-1:0]        req_next_hop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_BITS-1:0]     rsp_status,
   output logic [PORT_FIELD_BITS-1:0] rsp_out_port,
   output logic [HOP_BITS-1:0]        rsp_out_next_hop
);

   logic   f_valid, f_ready;
   op_type f_op;
   logic   q_valid, q_ready;
   op_type q_op;

   bslpm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_address      (req_address),
      .req_prefix_bytes (req_prefix_bytes),
      .req_port         (req_port),
      .req_next_hop     (req_next_hop),
      .op_valid         (f_valid),
      .op_ready         (f_ready),
      .op               (f_op)
   );

   bslpm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_op     (f_op),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_op    (q_op)
   );

   bslpm_back #(.ROUTES(ROUTES), .PORT_BITS(PORT_BITS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .op_valid         (q_valid),
      .op_ready         (q_ready),
      .op               (q_op),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_out_port     (rsp_out_port),
      .rsp_out_next_hop (rsp_out_next_hop)
   );

endmodule
